[rtl/core/afd_pkg.sv]
// Package with the shared types and constants of the adaptive frame dropper.
package afd_pkg;

    localparam int RATE_W     = 7;
    localparam int SPEED_W    = 10;
    localparam int DIVR_W     = 8;
    localparam int DIVIDEND_W = RATE_W + DIVR_W;
    localparam int POLICY_W   = 3;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [POLICY_W-1:0] POL_NONE      = 3'd0;
    localparam logic [POLICY_W-1:0] POL_DROP      = 3'd1;
    localparam logic [POLICY_W-1:0] POL_SLOW      = 3'd2;
    localparam logic [POLICY_W-1:0] POL_SLOW_DROP = 3'd3;
    localparam logic [POLICY_W-1:0] POL_DROP_SLOW = 3'd4;

    localparam logic [1:0] REG_NATIVE_RATE = 2'd0;
    localparam logic [1:0] REG_POLICY      = 2'd1;
    localparam logic [1:0] REG_MIN_RATE    = 2'd2;
    localparam logic [1:0] REG_MIN_SPEED   = 2'd3;

    localparam logic [RATE_W-1:0]   NATIVE_RATE_RST = 7'd30;
    localparam logic [RATE_W-1:0]   MIN_RATE_RST    = 7'd15;
    localparam logic [SPEED_W-1:0]  MIN_SPEED_RST   = 10'd90;
    localparam logic [SPEED_W-1:0]  SPEED_MAX       = 10'd1023;
    localparam logic [DIVR_W-1:0]   DIVR_MAX        = 8'd255;
    localparam logic [DIVR_W-1:0]   DIVR_KEEP_EDGE  = 8'd2;

    typedef struct packed {
        logic signed [1:0]    drop_request;
        logic [SPEED_W-1:0]   cur_speed;
        logic                 key_frame;
    } afd_in_t;

    typedef struct packed {
        logic                 drop_frame;
        logic [SPEED_W-1:0]   new_play_speed;
        logic [RATE_W-1:0]    effective_frame_rate;
    } afd_out_t;

    typedef struct packed {
        logic [RATE_W-1:0]    native_frame_rate;
        logic [POLICY_W-1:0]  smooth_policy;
        logic [RATE_W-1:0]    min_frame_rate;
        logic [SPEED_W-1:0]   min_play_speed;
    } afd_cfg_t;

endpackage

[rtl/core/adaptive_frame_dropper_top.sv]
// Top level of the adaptive frame dropper: sequencer, dropper state and result register.
//
//  Channel   Direction  Handshake              Payload
//  src       in         src_valid / src_stall  afd_in_t  (lag, speed, key-frame flag)
//  res       out        res_valid / res_stall  afd_out_t (drop flag, new speed, rate)
//  apb       in/out     psel/penable/pready    four registers at byte addresses 0..12
//
//  While the drop divider is non-zero, a transaction runs through the 15-step serial
//  divider that works out the effective frame rate; while it is zero, the divider is
//  skipped and the native rate is used.
//  Reset is asynchronous and active low; it restores the register defaults and the
//  dropper state (divider 0, countdown 1, drop mode).
//  A stall on the result side only holds the sequencer in its final step once the
//  result register is full; a new input is taken only when the sequencer is idle.
module adaptive_frame_dropper_top
    import afd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                src_valid,
    output logic                src_stall,
    input  afd_in_t             src_data,
    output logic                res_valid,
    input  logic                res_stall,
    output afd_out_t            res_data
);

    // Sequencer state codes.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    afd_cfg_t               cfg;
    logic [1:0]             state_reg,   state_next;
    afd_in_t                item_reg,    item_next;
    logic [RATE_W-1:0]      rate_reg,    rate_next;
    logic [DIVR_W-1:0]      divr_reg,    divr_next;
    logic [DIVR_W-1:0]      cnt_reg,     cnt_next;
    logic                   keep_reg,    keep_next;
    logic                   res_valid_reg, res_valid_next;
    afd_out_t               res_data_reg,  res_data_next;

    logic                   src_take;
    logic                   res_free;
    logic                   div_start;
    logic                   div_done;
    logic [DIVIDEND_W-1:0]  div_dividend;
    logic [DIVIDEND_W-1:0]  div_quotient;

    logic signed [1:0]      drop_req;
    logic signed [1:0]      slow_req;
    logic                   rate_le_min;
    logic                   speed_le_min;
    logic signed [SPEED_W+1:0] speed_wide;
    logic [SPEED_W-1:0]     speed_new;
    logic                   drop_up;
    logic                   drop_down;
    logic [DIVR_W-1:0]      divr_step;
    logic                   keep_step;
    logic [DIVR_W-1:0]      cnt_step;
    logic [DIVR_W-1:0]      cnt_dec;
    logic                   drop_hit;
    logic                   drop_out;

    afd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready = 1'b1;

    // New input is only taken while the sequencer is idle.
    assign src_stall = (state_reg != S_IDLE);
    assign src_take  = src_valid && !src_stall;
    assign res_free  = !res_valid_reg || !res_stall;

    // In keep mode the rate is native/divider; in drop mode it is
    // native*(divider-1)/divider. The small multiply is done at acceptance.
    assign div_start    = src_take && (divr_reg != '0);
    assign div_dividend = keep_reg ? DIVIDEND_W'(cfg.native_frame_rate)
                                   : DIVIDEND_W'(cfg.native_frame_rate)
                                     * DIVIDEND_W'(divr_reg - 1'b1);

    afd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (divr_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Smoothing policy: split the lag into a drop request and a slow-down request.
    assign rate_le_min  = rate_reg <= cfg.min_frame_rate;
    assign speed_le_min = item_reg.cur_speed <= cfg.min_play_speed;

    always_comb
    begin
        drop_req = item_reg.drop_request;
        slow_req = item_reg.drop_request;
        case (cfg.smooth_policy)
            POL_DROP:
            begin
                slow_req = '0;
                if (rate_le_min)
                    drop_req = '0;
            end
            POL_SLOW:
            begin
                drop_req = '0;
                if (speed_le_min)
                    slow_req = '0;
            end
            POL_SLOW_DROP:
            begin
                if (!speed_le_min)
                    drop_req = '0;
                else
                    slow_req = '0;
            end
            POL_DROP_SLOW:
            begin
                if (!rate_le_min)
                    slow_req = '0;
                else
                    drop_req = '0;
            end
            default:
            begin
                drop_req = '0;
                slow_req = '0;
            end
        endcase
    end

    // The new speed saturates at both ends of its range.
    assign speed_wide = $signed({2'b00, item_reg.cur_speed})
                      - $signed({{SPEED_W{slow_req[1]}}, slow_req});

    always_comb
    begin
        if (speed_wide[SPEED_W+1])
            speed_new = '0;
        else if (speed_wide[SPEED_W])
            speed_new = SPEED_MAX;
        else
            speed_new = speed_wide[SPEED_W-1:0];
    end

    // Divider and mode update from the drop request.
    assign drop_up   = !drop_req[1] && drop_req[0];
    assign drop_down = drop_req[1];

    always_comb
    begin
        divr_step = divr_reg;
        keep_step = keep_reg;
        if (drop_up)
        begin
            if (keep_reg)
            begin
                divr_step = (divr_reg == DIVR_MAX) ? DIVR_MAX : divr_reg + 1'b1;
            end
            else if (divr_reg == '0)
            begin
                divr_step = DIVR_W'(cfg.native_frame_rate);
            end
            else
            begin
                divr_step = divr_reg - 1'b1;
                if (divr_step == DIVR_KEEP_EDGE)
                    keep_step = 1'b1;
            end
        end
        else if (drop_down)
        begin
            if (keep_reg)
            begin
                if (divr_reg != '0)
                begin
                    divr_step = divr_reg - 1'b1;
                    if (divr_step == DIVR_KEEP_EDGE)
                        keep_step = 1'b0;
                end
            end
            else if (divr_reg != '0)
            begin
                if (divr_reg == DIVR_W'(cfg.native_frame_rate))
                    divr_step = '0;
                else
                    divr_step = (divr_reg == DIVR_MAX) ? DIVR_MAX : divr_reg + 1'b1;
            end
        end
    end

    // The countdown is clocked for every frame that is not a key frame while
    // dropping is active; its expiry marks the one frame in each period.
    assign cnt_dec = cnt_reg - 1'b1;

    always_comb
    begin
        cnt_step = cnt_reg;
        drop_hit = 1'b0;
        drop_out = 1'b0;
        if (!item_reg.key_frame && (divr_step != '0))
        begin
            if (cnt_dec == '0)
            begin
                cnt_step = divr_step;
                drop_hit = 1'b1;
            end
            else
            begin
                cnt_step = cnt_dec;
            end
            drop_out = keep_step ^ drop_hit;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        rate_next      = rate_reg;
        divr_next      = divr_reg;
        cnt_next       = cnt_reg;
        keep_next      = keep_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (src_take)
                begin
                    item_next = src_data;
                    if (divr_reg == '0)
                    begin
                        rate_next  = cfg.native_frame_rate;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    rate_next  = div_quotient[RATE_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    divr_next      = divr_step;
                    keep_next      = keep_step;
                    cnt_next       = cnt_step;
                    res_valid_next = 1'b1;
                    res_data_next.drop_frame           = drop_out;
                    res_data_next.new_play_speed       = speed_new;
                    res_data_next.effective_frame_rate = rate_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            divr_reg      <= '0;
            cnt_reg       <= DIVR_W'(1);
            keep_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            divr_reg      <= divr_next;
            cnt_reg       <= cnt_next;
            keep_reg      <= keep_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        rate_reg     <= rate_next;
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // The divider reports a result only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider result outside the divide step");

    // The countdown is reloaded from a non-zero divider and so never reads zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0)
        else $error("drop countdown reached zero");

    // A new result appears only as the sequencer leaves its final step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result produced outside the final step");

endmodule

[rtl/core/afd_div.sv]
// Serial restoring divider, one quotient bit per cycle.
module afd_div
    import afd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [DIVR_W-1:0]       divisor,
    output logic                    done,
    output logic [DIVIDEND_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;
    logic [CNT_W-1:0]       cnt_reg,   cnt_next;
    logic [DIVR_W-1:0]      rem_reg,   rem_next;
    logic [DIVIDEND_W-1:0]  quo_reg,   quo_next;
    logic [DIVR_W-1:0]      divr_reg,  divr_next;
    logic [DIVR_W:0]        trial;
    logic [DIVR_W:0]        diff;
    logic                   fits;

    // Bring down the next dividend bit and try the subtraction.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divr_reg};
    assign fits  = trial >= {1'b0, divr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        divr_next = divr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            divr_next = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        divr_reg <= divr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // The result is only announced at the end of a run of steps.
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

    // The step counter never passes the last step while running.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= LAST_STEP)
        else $error("divider step count out of range");

    // The remainder always stays below the divisor after a step.
    assert property (@(posedge clk) disable iff (!rst_n)
        ($past(busy_reg) && !$past(start) && divr_reg != '0) |-> rem_reg < divr_reg)
        else $error("divider remainder not reduced");

endmodule

[rtl/core/afd_cfg.sv]
// APB-style configuration register bank of the adaptive frame dropper.
module afd_cfg
    import afd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output afd_cfg_t            cfg
);

    afd_cfg_t    cfg_reg, cfg_next;
    logic        wr_en;
    logic [1:0]  reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_NATIVE_RATE: cfg_next.native_frame_rate = pwdata[RATE_W-1:0];
                REG_POLICY:      cfg_next.smooth_policy     = pwdata[POLICY_W-1:0];
                REG_MIN_RATE:    cfg_next.min_frame_rate    = pwdata[RATE_W-1:0];
                REG_MIN_SPEED:   cfg_next.min_play_speed    = pwdata[SPEED_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_NATIVE_RATE: prdata = DATA_W'(cfg_reg.native_frame_rate);
            REG_POLICY:      prdata = DATA_W'(cfg_reg.smooth_policy);
            REG_MIN_RATE:    prdata = DATA_W'(cfg_reg.min_frame_rate);
            REG_MIN_SPEED:   prdata = DATA_W'(cfg_reg.min_play_speed);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.native_frame_rate <= NATIVE_RATE_RST;
            cfg_reg.smooth_policy     <= POL_NONE;
            cfg_reg.min_frame_rate    <= MIN_RATE_RST;
            cfg_reg.min_play_speed    <= MIN_SPEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[tb/sv/tb_adaptive_frame_dropper_top.sv]
// Self-checking testbench for the adaptive frame dropper: random and directed frames, APB setup.
`timescale 1ns / 100ps

module tb_adaptive_frame_dropper_top;

    import afd_pkg::*;

    // Run length guard. The limit leaves a wide margin over the slowest legal run: every frame
    // through the serial divider, plus idle and stall bursts on both sides, one long hold-off
    // and the register writes.
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_MAX    = 10;

    // Lag signal values as the renderer reports them. The two-bit field also allows -2,
    // which the block treats as an "ahead" step for the divider that raises the speed by two.
    localparam int LAG_FAR_AHEAD = -2;
    localparam int LAG_AHEAD     = -1;
    localparam int LAG_STEADY    = 0;
    localparam int LAG_BEHIND    = 1;

    typedef enum int {LEAN_MIXED, LEAN_BEHIND, LEAN_AHEAD} lag_lean_e;

    // Dropper state carried from frame to frame.
    typedef struct packed {
        logic [DIVR_W-1:0] divider;
        logic [DIVR_W-1:0] countdown;
        logic              keep_mode;
    } dropper_state_t;

    // One frame's outcome: the result transaction and the state left behind.
    typedef struct packed {
        afd_out_t       res;
        dropper_state_t nxt;
    } frame_step_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              src_valid = 1'b0;
    logic              src_stall;
    afd_in_t           src_data  = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    afd_out_t          res_data;

    // Frames waiting to be offered, and the results predicted for accepted frames.
    afd_in_t        frames_to_send[$];
    afd_out_t       predicted_frames[$];

    // Shadow of the registers and of the dropper state, as the block should hold them.
    afd_cfg_t       regs_now;
    dropper_state_t dropper_now;

    // Idle control for the stimulus process and the two channel processes.
    bit             calm       = 1'b0;
    bit             want_hold  = 1'b0;
    bit             hold_taken = 1'b0;
    int             hold_left  = 0;
    int             send_gap   = 0;
    int             sink_gap   = 0;

    int             fault_count  = 0;
    int             results_seen = 0;
    int             cycle_count  = 0;

    // Working variables of the sender and receiver processes.
    bit             offer;
    bit             stall_next;
    frame_step_t    stepped;
    afd_out_t       want;

    adaptive_frame_dropper_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Works out what one frame does to the dropper. The effective rate is taken from the
    // state before the update; the smoothing policy then splits the lag into a drop step
    // and a slow-down step, the divider and mode move, and the countdown decides the drop.
    function automatic frame_step_t advance_frame(input dropper_state_t st, input afd_cfg_t cfg,
                                                  input afd_in_t fr);
        int unsigned nat;
        int unsigned div;
        int unsigned cnt;
        int unsigned rate;
        int          lag;
        int          drop_step;
        int          slow_step;
        int          speed;
        int          ns;
        bit          keep;
        bit          hit;
        bit          drop;
        frame_step_t r;

        nat   = 32'(cfg.native_frame_rate);
        div   = 32'(st.divider);
        cnt   = 32'(st.countdown);
        keep  = st.keep_mode;
        lag   = int'($signed(fr.drop_request));
        speed = int'(fr.cur_speed);
        drop  = 1'b0;

        // The rate is widened before the product so that nothing is lost to truncation.
        if (div == 0)
            rate = nat;
        else if (keep)
            rate = nat / div;
        else
            rate = nat * (div - 1) / div;

        drop_step = lag;
        slow_step = lag;
        case (cfg.smooth_policy)
            POL_DROP:
            begin
                slow_step = 0;
                if (rate <= cfg.min_frame_rate)
                    drop_step = 0;
            end
            POL_SLOW:
            begin
                drop_step = 0;
                if (speed <= cfg.min_play_speed)
                    slow_step = 0;
            end
            POL_SLOW_DROP:
            begin
                if (speed > cfg.min_play_speed)
                    drop_step = 0;
                else
                    slow_step = 0;
            end
            POL_DROP_SLOW:
            begin
                if (rate > cfg.min_frame_rate)
                    slow_step = 0;
                else
                    drop_step = 0;
            end
            default:
            begin
                // Unassigned policy codes behave as no smoothing at all.
                drop_step = 0;
                slow_step = 0;
            end
        endcase

        // A far-ahead lag of -2 raises the speed by two; both ends saturate.
        ns = speed - slow_step;
        if (ns < 0)
            ns = 0;
        if (ns > int'(SPEED_MAX))
            ns = int'(SPEED_MAX);

        if (drop_step > 0)
        begin
            if (keep)
                div = (div >= DIVR_MAX) ? DIVR_MAX : div + 1;
            else if (div == 0)
                div = nat;
            else
            begin
                div = div - 1;
                if (div == DIVR_KEEP_EDGE)
                    keep = 1'b1;
            end
        end
        else if (drop_step < 0)
        begin
            if (keep)
            begin
                // A zero divider in keep mode has nowhere lower to go.
                if (div != 0)
                begin
                    div = div - 1;
                    if (div == DIVR_KEEP_EDGE)
                        keep = 1'b0;
                end
            end
            else if (div != 0)
            begin
                // Stepping ahead from the native rate switches dropping off.
                if (div == nat)
                    div = 0;
                else
                    div = (div >= DIVR_MAX) ? DIVR_MAX : div + 1;
            end
        end

        // Key frames never drop and leave the countdown alone.
        if (!fr.key_frame && div != 0)
        begin
            cnt = (cnt - 1) & 8'hFF;
            hit = (cnt == 0);
            if (hit)
                cnt = div;
            drop = keep ? !hit : hit;
        end

        r.res.drop_frame           = drop;
        r.res.new_play_speed       = ns[SPEED_W-1:0];
        r.res.effective_frame_rate = rate[RATE_W-1:0];
        r.nxt.divider              = div[DIVR_W-1:0];
        r.nxt.countdown            = cnt[DIVR_W-1:0];
        r.nxt.keep_mode            = keep;
        return r;
    endfunction

    function automatic afd_in_t make_frame(input int lag, input int speed, input bit key);
        afd_in_t fr;
        fr.drop_request = lag[1:0];
        fr.cur_speed    = speed[SPEED_W-1:0];
        fr.key_frame    = key;
        return fr;
    endfunction

    // Speeds lean towards the extremes and the configured floor, where the policies turn.
    function automatic int rand_speed();
        int s;
        case ($urandom_range(0, 9))
            0: s = 0;
            1: s = int'(SPEED_MAX);
            2:
            begin
                s = int'(regs_now.min_play_speed) + int'($urandom_range(0, 2)) - 1;
                if (s < 0)
                    s = 0;
                if (s > int'(SPEED_MAX))
                    s = int'(SPEED_MAX);
            end
            default: s = $urandom_range(0, SPEED_MAX);
        endcase
        return s;
    endfunction

    function automatic int rand_lag(input lag_lean_e lean);
        int lag;
        lag = int'($urandom_range(0, 3)) + LAG_FAR_AHEAD;
        if (lean == LEAN_BEHIND && $urandom_range(0, 99) < 85)
            lag = LAG_BEHIND;
        if (lean == LEAN_AHEAD)
            lag = $urandom_range(0, 1) ? LAG_AHEAD : LAG_FAR_AHEAD;
        return lag;
    endfunction

    task automatic queue_frames(input int count, input lag_lean_e lean);
        for (int i = 0; i < count; i++)
            frames_to_send.push_back(make_frame(rand_lag(lean), rand_speed(),
                                                $urandom_range(0, 3) == 0));
    endtask

    // One APB write: a setup cycle, then an access cycle that completes when pready is seen.
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NATIVE_RATE: regs_now.native_frame_rate = value[RATE_W-1:0];
            REG_POLICY:      regs_now.smooth_policy     = value[POLICY_W-1:0];
            REG_MIN_RATE:    regs_now.min_frame_rate    = value[RATE_W-1:0];
            REG_MIN_SPEED:   regs_now.min_play_speed    = value[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [RATE_W-1:0] native, input logic [POLICY_W-1:0] pol,
                              input logic [RATE_W-1:0] min_rate,
                              input logic [SPEED_W-1:0] min_speed);
        write_reg(REG_NATIVE_RATE, DATA_W'(native));
        write_reg(REG_POLICY, DATA_W'(pol));
        write_reg(REG_MIN_RATE, DATA_W'(min_rate));
        write_reg(REG_MIN_SPEED, DATA_W'(min_speed));
    endtask

    // Registers are only touched with the block idle: every frame sent and every result back,
    // followed by a pause at least as long as one transaction through the serial divider.
    task automatic drain();
        while (frames_to_send.size() != 0 || src_valid || predicted_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus. A directed part walks the corner cases, then random phases run under a
    // series of register settings. Some phases steer the dropper on purpose so that the
    // random content lands in keep mode, back at a zero divider and in divider saturation.
    initial
    begin
        dropper_state_t probe;
        frame_step_t    sim;
        afd_in_t        fr;
        int             lag;
        int             n;

        regs_now.native_frame_rate = NATIVE_RATE_RST;
        regs_now.smooth_policy     = POL_NONE;
        regs_now.min_frame_rate    = MIN_RATE_RST;
        regs_now.min_play_speed    = MIN_SPEED_RST;
        dropper_now.divider        = '0;
        dropper_now.countdown      = 8'd1;
        dropper_now.keep_mode      = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: no smoothing, so the speed passes through and nothing drops.
        frames_to_send.push_back(make_frame(LAG_BEHIND, SPEED_MAX, 1'b0));
        frames_to_send.push_back(make_frame(LAG_FAR_AHEAD, 0, 1'b1));
        frames_to_send.push_back(make_frame(LAG_STEADY, 512, 1'b0));
        drain();

        // Slowing only: saturation at both speed ends and the speed floor.
        set_config(7'd30, POL_SLOW, 7'd15, 10'd90);
        frames_to_send.push_back(make_frame(LAG_FAR_AHEAD, SPEED_MAX, 1'b0));
        frames_to_send.push_back(make_frame(LAG_BEHIND, 0, 1'b0));
        frames_to_send.push_back(make_frame(LAG_BEHIND, 91, 1'b1));
        frames_to_send.push_back(make_frame(LAG_AHEAD, SPEED_MAX, 1'b0));
        frames_to_send.push_back(make_frame(LAG_BEHIND, SPEED_MAX, 1'b0));
        frames_to_send.push_back(make_frame(LAG_STEADY, 90, 1'b0));
        frames_to_send.push_back(make_frame(LAG_BEHIND, 90, 1'b0));
        drain();

        // Dropping only with a small native rate: into keep mode and back out, then off
        // again by stepping ahead from the native rate.
        set_config(7'd4, POL_DROP, 7'd0, 10'd90);
        frames_to_send.push_back(make_frame(LAG_BEHIND, 0, 1'b0));
        frames_to_send.push_back(make_frame(LAG_BEHIND, SPEED_MAX, 1'b0));
        frames_to_send.push_back(make_frame(LAG_BEHIND, 5, 1'b0));
        frames_to_send.push_back(make_frame(LAG_BEHIND, 5, 1'b1));
        frames_to_send.push_back(make_frame(LAG_AHEAD, 5, 1'b0));
        frames_to_send.push_back(make_frame(LAG_FAR_AHEAD, 5, 1'b0));
        frames_to_send.push_back(make_frame(LAG_AHEAD, 5, 1'b0));
        frames_to_send.push_back(make_frame(LAG_AHEAD, 5, 1'b0));
        drain();

        // A native rate of zero: a behind step leaves the divider at zero, rates read zero.
        set_config(7'd0, POL_SLOW_DROP, 7'd100, SPEED_MAX);
        frames_to_send.push_back(make_frame(LAG_BEHIND, 600, 1'b0));
        frames_to_send.push_back(make_frame(LAG_AHEAD, SPEED_MAX, 1'b0));
        drain();

        // Drop-then-slow with the rate at its floor falls back to slowing.
        set_config(7'd0, POL_DROP_SLOW, 7'd0, 10'd500);
        frames_to_send.push_back(make_frame(LAG_BEHIND, 0, 1'b0));
        frames_to_send.push_back(make_frame(LAG_FAR_AHEAD, 1022, 1'b1));
        drain();

        // Mostly behind: the divider starts at the native rate, walks down into keep mode
        // and climbs from there.
        set_config(7'd30, POL_DROP, 7'd0, 10'd90);
        queue_frames(70, LEAN_BEHIND);
        drain();

        // Mixed lag under drop-then-slow. Part way through, the receiver holds off for a
        // long stretch while frames keep coming, so the block has to stall its input.
        set_config(7'd100, POL_DROP_SLOW, 7'd20, 10'd512);
        queue_frames(90, LEAN_MIXED);
        repeat (30) @(posedge clk);
        want_hold = 1'b1;
        drain();

        // Dropping with a rate floor that the keep-mode rates soon fall under.
        set_config(7'd60, POL_DROP, 7'd40, 10'd0);
        queue_frames(60, LEAN_MIXED);
        drain();

        // Unassigned policy codes: the lag neither moves the divider nor changes the speed.
        set_config(7'd55, POL_DROP_SLOW + 3'($urandom_range(1, 3)), 7'd15, 10'd90);
        queue_frames(40, LEAN_MIXED);
        drain();

        // Steer back to a zero divider in drop mode. With every speed at or under the floor
        // the lag goes straight to the divider; each step is chosen from the predicted state.
        set_config(7'd3, POL_SLOW_DROP, 7'd0, SPEED_MAX);
        probe = dropper_now;
        n     = 0;
        while ((probe.divider != 0 || probe.keep_mode) && n < 300)
        begin
            if (probe.keep_mode)
                lag = (probe.divider >= 3) ? LAG_AHEAD : LAG_BEHIND;
            else
                lag = (probe.divider > regs_now.native_frame_rate) ? LAG_BEHIND : LAG_AHEAD;
            if (lag == LAG_AHEAD && $urandom_range(0, 1))
                lag = LAG_FAR_AHEAD;
            fr    = make_frame(lag, rand_speed(), $urandom_range(0, 3) == 0);
            sim   = advance_frame(probe, regs_now, fr);
            probe = sim.nxt;
            frames_to_send.push_back(fr);
            n++;
        end
        drain();

        // One behind step at the largest native rate lifts the divider to 127; with the
        // native rate then lowered, a run of ahead steps drives it into saturation at 255.
        set_config(7'd127, POL_DROP_SLOW, 7'd0, 10'd512);
        frames_to_send.push_back(make_frame(LAG_BEHIND, rand_speed(), $urandom_range(0, 1) == 1));
        drain();
        set_config(7'd20, POL_DROP_SLOW, 7'd0, 10'd512);
        queue_frames(130, LEAN_AHEAD);
        queue_frames(20, LEAN_MIXED);
        drain();

        // Last phase runs without idling on either side.
        calm = 1'b1;
        set_config(7'd127, POL_SLOW_DROP, 7'd127, SPEED_W'($urandom_range(0, SPEED_MAX)));
        queue_frames(60, LEAN_MIXED);

        while (frames_to_send.size() != 0 || predicted_frames.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fault_count == 0 && predicted_frames.size() == 0)
            $display("tb_adaptive_frame_dropper_top OK");
        else
            $display("tb_adaptive_frame_dropper_top NOT OK");
        $finish;
    end

    // Sender. On acceptance the frame is run through the predictor and its result queued.
    // Valid is decided once per edge, so a frame offered back to back keeps valid high.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            offer = src_valid;
            if (src_valid && !src_stall)
            begin
                stepped     = advance_frame(dropper_now, regs_now, src_data);
                dropper_now = stepped.nxt;
                predicted_frames.push_back(stepped.res);
                void'(frames_to_send.pop_front());
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (send_gap == 0 && !calm && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 12);
                if (send_gap != 0)
                    send_gap--;
                else if (frames_to_send.size() != 0)
                begin
                    src_data <= frames_to_send[0];
                    offer = 1'b1;
                end
            end
            src_valid <= offer;
        end
    end

    // Receiver. Each accepted result transaction is checked against the oldest prediction,
    // field by field. Stalls come in short random bursts, plus the one long hold-off.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (predicted_frames.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("unexpected result: drop=%0d speed=%0d rate=%0d",
                                 res_data.drop_frame, res_data.new_play_speed,
                                 res_data.effective_frame_rate);
                end
                else
                begin
                    want = predicted_frames.pop_front();
                    if (res_data.drop_frame !== want.drop_frame ||
                        res_data.new_play_speed !== want.new_play_speed ||
                        res_data.effective_frame_rate !== want.effective_frame_rate)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                        begin
                            $write("frame %0d: expected drop=%0d speed=%0d rate=%0d, ",
                                   results_seen, want.drop_frame, want.new_play_speed,
                                   want.effective_frame_rate);
                            $display("got drop=%0d speed=%0d rate=%0d",
                                     res_data.drop_frame, res_data.new_play_speed,
                                     res_data.effective_frame_rate);
                        end
                    end
                end
                results_seen++;
            end

            if (want_hold && !hold_taken)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                stall_next = 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                sink_gap   = $urandom_range(1, 12) - 1;
                stall_next = 1'b1;
            end
            else
                stall_next = 1'b0;
            res_stall <= stall_next;
        end
    end

    // Watchdog against a hung block.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_adaptive_frame_dropper_top NOT OK");
            $finish;
        end
    end

endmodule
